### src/rtp_pkg.sv
// Package for the rectangular-to-polar converter.
// Holds fixed-point formats, default sizes and the CORDIC arctangent table.
// No dependencies.
package rtp_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_ITERATIONS = 16;

    // Fractional bits carried on x and y inside the rotation stages.
    localparam int FRAC_BITS = 24;
    // Angle accumulator width; a full circle spans 2^ANGLE_W.
    localparam int ANGLE_W = 32;
    localparam int ATAN_ENTRIES = 24;

    // Inverse CORDIC gain, round(0.60725293500888 * 2^32).
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    localparam logic [ANGLE_W-1:0] ANGLE_PI = 32'h8000_0000;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ANGLE_W-1:0] atan_step(input int idx);
        logic [ANGLE_W-1:0] val;
        unique case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### src/rtp_cordic_stage.sv
// One vectoring micro-rotation of the CORDIC pipeline, with its registers.
// Depends on rtp_pkg for the angle width and the arctangent table.
module rtp_cordic_stage
    import rtp_pkg::*;
#(
    parameter int XY_W  = 43,
    parameter int STAGE = 0
) (
    input  logic                    aclk,
    input  logic                    load,
    input  logic signed [XY_W-1:0]  x_in,
    input  logic signed [XY_W-1:0]  y_in,
    input  logic [ANGLE_W-1:0]      z_in,
    input  logic                    zero_in,
    output logic signed [XY_W-1:0]  x_out,
    output logic signed [XY_W-1:0]  y_out,
    output logic [ANGLE_W-1:0]      z_out,
    output logic                    zero_out
);

    localparam logic [ANGLE_W-1:0] STEP = atan_step(STAGE);

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic [ANGLE_W-1:0]     z_reg, z_next;
    logic                   zero_reg;
    logic signed [XY_W-1:0] x_sh, y_sh;

    // Arithmetic shifts round toward minus infinity.
    assign x_sh = x_in >>> STAGE;
    assign y_sh = y_in >>> STAGE;

    always_comb begin
        if (!y_in[XY_W-1]) begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + STEP;
        end else begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign zero_out = zero_reg;

endmodule

### src/rtp_gain.sv
// Two-stage gain correction: scales the final CORDIC x by the inverse gain,
// rounds to the input scale and saturates. Depends on rtp_pkg.
module rtp_gain
    import rtp_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int XY_W       = DATA_WIDTH + FRAC_BITS + 3
) (
    input  logic                    aclk,
    input  logic                    load_prod,
    input  logic                    load_out,
    input  logic signed [XY_W-1:0]  x_in,
    output logic [DATA_WIDTH-1:0]   magnitude
);

    localparam int UX_W  = XY_W - 1;
    localparam int HI_W  = UX_W - 32;
    localparam int PHI_W = HI_W + 32;
    localparam int T_W   = HI_W + 33;
    localparam int M_W   = T_W - FRAC_BITS;

    logic [UX_W-1:0]       ux;
    logic [31:0]           lo_part;
    logic [HI_W-1:0]       hi_part;
    logic [63:0]           p_lo_reg, p_lo_next;
    logic [PHI_W-1:0]      p_hi_reg, p_hi_next;
    logic [T_W-1:0]        t_sum, t_round;
    logic [M_W-1:0]        m_full;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;

    // The 64-bit product is split into a low 32x32 and a narrow high part.
    assign ux        = (!x_in[XY_W-1] && (x_in != '0)) ? x_in[UX_W-1:0] : '0;
    assign lo_part   = ux[31:0];
    assign hi_part   = ux[UX_W-1:32];
    assign p_lo_next = 64'(lo_part) * 64'(GAIN_Q32);
    assign p_hi_next = PHI_W'(hi_part) * PHI_W'(GAIN_Q32);

    assign t_sum   = T_W'(p_hi_reg) + T_W'(p_lo_reg[63:32]);
    assign t_round = t_sum + (T_W'(1) << (FRAC_BITS - 1));
    assign m_full  = t_round[T_W-1:FRAC_BITS];

    always_comb begin
        if (m_full[M_W-1:DATA_WIDTH] != '0) begin
            mag_next = '1;
        end else begin
            mag_next = m_full[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_prod) begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (load_out) begin
            mag_reg <= mag_next;
        end
    end

    assign magnitude = mag_reg;

endmodule

### src/rect_to_polar_converter.sv
// Top level of the rectangular-to-polar converter (pipelined CORDIC vectoring).
// Depends on rtp_pkg, rtp_cordic_stage and rtp_gain.
//
//  Channel  Direction  Payload (lowest bits first)            Beat rule
//  s_       in         tdata: x_coord, y_coord                 tvalid & tready
//  m_       out        tdata: magnitude, phase_angle           tvalid & tready
//
// One beat enters per clock cycle while no back-pressure stalls the
// pipeline. The stages are quadrant folding, one per CORDIC micro-rotation,
// the gain product, and rounding and saturation.
// aresetn is synchronous and active low; it empties the pipeline (valid bits
// only, data registers keep whatever they hold).
// Every stage moves forward when it is empty or when the stage after it
// moves, so bubbles are squeezed out while the output beat waits and no
// beat is lost or repeated under back-pressure.
module rect_to_polar_converter
    import rtp_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ITERATIONS = DEF_ITERATIONS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // Input beat fields: x_coord, y_coord (signed, DATA_WIDTH each).
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
    // Output beat fields: magnitude (unsigned), phase_angle (signed).
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_tdata
);

    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;
    // Magnitude reaches 1.65 * sqrt(2) * 2^(DATA_WIDTH-1) during rotation,
    // so three guard bits above the input width are enough.
    localparam int XY_W    = DATA_WIDTH + FRAC_BITS + 3;
    // Stages: fold, ITERATIONS rotations, product, output.
    localparam int NST     = ITERATIONS + 3;
    localparam int PROD_ST = ITERATIONS + 1;
    localparam int OUT_ST  = ITERATIONS + 2;
    localparam int SH      = ANGLE_W - DATA_WIDTH;
    localparam logic [ANGLE_W:0] ANG_ROUND = ((ANGLE_W+1)'(1) << SH) >> 1;

    // Stage valid bits and the advance chain.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Quadrant folding: points in the left half plane are turned by pi
    // so that the rotations only have to cover +/- pi/2.
    logic signed [DATA_WIDTH-1:0] x_in, y_in;
    logic signed [XY_W-1:0]       x_ext, y_ext;
    logic                         neg_x;
    logic signed [XY_W-1:0]       x0_next, y0_next;

    assign x_in   = s_tdata[DATA_WIDTH-1:0];
    assign y_in   = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign x_ext  = XY_W'(x_in);
    assign y_ext  = XY_W'(y_in);
    assign neg_x  = x_in[DATA_WIDTH-1];
    assign x0_next = (neg_x ? -x_ext : x_ext) <<< FRAC_BITS;
    assign y0_next = (neg_x ? -y_ext : y_ext) <<< FRAC_BITS;

    logic signed [XY_W-1:0] x_s    [0:ITERATIONS];
    logic signed [XY_W-1:0] y_s    [0:ITERATIONS];
    logic [ANGLE_W-1:0]     z_s    [0:ITERATIONS];
    logic                   zero_s [0:ITERATIONS];

    logic signed [XY_W-1:0] x0_reg, y0_reg;
    logic [ANGLE_W-1:0]     z0_reg;
    logic                   zero0_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= neg_x ? ANGLE_PI : '0;
            zero0_reg <= (x_in == '0) && (y_in == '0);
        end
    end

    assign x_s[0]    = x0_reg;
    assign y_s[0]    = y0_reg;
    assign z_s[0]    = z0_reg;
    assign zero_s[0] = zero0_reg;

    // One micro-rotation per stage.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        rtp_cordic_stage #(
            .XY_W  (XY_W),
            .STAGE (i)
        ) u_stage (
            .aclk     (aclk),
            .load     (adv[i+1]),
            .x_in     (x_s[i]),
            .y_in     (y_s[i]),
            .z_in     (z_s[i]),
            .zero_in  (zero_s[i]),
            .x_out    (x_s[i+1]),
            .y_out    (y_s[i+1]),
            .z_out    (z_s[i+1]),
            .zero_out (zero_s[i+1])
        );
    end

    // Gain correction runs in the product and output stages.
    logic [DATA_WIDTH-1:0] magnitude;

    rtp_gain #(
        .DATA_WIDTH (DATA_WIDTH),
        .XY_W       (XY_W)
    ) u_gain (
        .aclk      (aclk),
        .load_prod (adv[PROD_ST]),
        .load_out  (adv[OUT_ST]),
        .x_in      (x_s[ITERATIONS]),
        .magnitude (magnitude)
    );

    // The angle is rounded half up to the output width in the product stage
    // and carried through the output stage. A zero point reports angle 0.
    logic [ANGLE_W:0]      ang_sum;
    logic [DATA_WIDTH-1:0] ang_p_reg, ang_out_reg;
    logic                  zero_p_reg, zero_out_reg;

    assign ang_sum = {1'b0, z_s[ITERATIONS]} + ANG_ROUND;

    always_ff @(posedge aclk) begin
        if (adv[PROD_ST]) begin
            ang_p_reg  <= zero_s[ITERATIONS] ? '0 : ang_sum[SH +: DATA_WIDTH];
            zero_p_reg <= zero_s[ITERATIONS];
        end
        if (adv[OUT_ST]) begin
            ang_out_reg  <= ang_p_reg;
            zero_out_reg <= zero_p_reg;
        end
    end

    assign m_tvalid = valid_reg[OUT_ST];
    assign m_tdata  = TDATA_W'({ang_out_reg, magnitude});

    // An empty output stage lets the whole pipeline move, so input is taken.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[OUT_ST] |-> s_tready)
        else $error("input stalled while the output stage is empty");

    // A full fold stage that could not advance still holds its beat.
    a_fold_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && !adv[0] |=> valid_reg[0])
        else $error("fold stage dropped a stalled beat");

    // A zero point leaves the pipeline as magnitude 0 and angle 0.
    a_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zero_out_reg |-> (magnitude == '0) && (ang_out_reg == '0))
        else $error("zero point gave a nonzero result");

endmodule

### verif/rtp_checker.sv
// Scoreboard for the rectangular-to-polar converter: watches both stream channels,
// predicts magnitude and angle for every accepted point and compares the results.
// Depends on rtp_pkg for the fixed-point formats and the gain constant.
module rtp_checker
    import rtp_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ITERATIONS = DEF_ITERATIONS,
    parameter int BUS_W      = ((2*DATA_WIDTH+7)/8)*8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [BUS_W-1:0] s_tdata,   // x_coord, y_coord
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [BUS_W-1:0] m_tdata,   // magnitude, phase_angle
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH;

    // Arctangent steps, round(atan(2^-i) * 2^31 / pi), entry 0 in the lowest word.
    localparam logic [32*24-1:0] ARC_STEPS = {
        32'd81,      32'd163,     32'd326,     32'd652,
        32'd1304,    32'd2608,    32'd5215,    32'd10430,
        32'd20861,   32'd41722,   32'd83443,   32'd166886,
        32'd333772,  32'd667544,  32'd1335087, 32'd2670163,
        32'd5340245, 32'd10679838, 32'd21354465, 32'd42667331,
        32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
    };

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic        [DW-1:0] mag;
        logic signed [DW-1:0] ang;
    } polar_point_t;

    polar_point_t polar_expected[$];
    int           mismatches = 0;

    function automatic polar_point_t polar_of(logic signed [DW-1:0] xin,
                                              logic signed [DW-1:0] yin);
        longint            xv;
        longint            yv;
        longint            xs;
        longint            ys;
        logic [31:0]       z;
        logic [32:0]       z_round;
        longint unsigned   ux;
        longint unsigned   hi;
        longint unsigned   lo;
        longint unsigned   prod;
        longint unsigned   mag;
        polar_point_t      r;
        r     = '0;
        r.x   = xin;
        r.y   = yin;
        xv    = longint'(xin);
        yv    = longint'(yin);
        if (xv == 0 && yv == 0) begin
            return r;
        end
        z = '0;
        // Fold the left half plane onto the right one by a half turn.
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            z  = ANGLE_PI;
        end
        xv = xv * (longint'(1) << FRAC_BITS);
        yv = yv * (longint'(1) << FRAC_BITS);
        for (int i = 0; i < ITERATIONS && i < ATAN_ENTRIES; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                z  = z + ARC_STEPS[i*32 +: 32];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                z  = z - ARC_STEPS[i*32 +: 32];
            end
        end
        ux   = (xv > 0) ? longint'(xv) : 64'd0;
        hi   = ux >> 32;
        lo   = ux & 64'hFFFF_FFFF;
        prod = hi * GAIN_Q32 + ((lo * GAIN_Q32) >> 32);
        mag  = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (mag > (64'd1 << DW) - 1) begin
            mag = (64'd1 << DW) - 1;
        end
        r.mag   = mag[DW-1:0];
        // Round the accumulator half up to the output width; a +pi result wraps.
        z_round = {1'b0, z} + (33'd1 << (32 - DW - 1));
        r.ang   = z_round[32-DW +: DW];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        polar_point_t            want;
        logic        [DW-1:0]    got_mag;
        logic signed [DW-1:0]    got_ang;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                polar_expected.push_back(polar_of(s_tdata[DW-1:0], s_tdata[2*DW-1:DW]));
            end
            if (m_tvalid && m_tready) begin
                got_mag = m_tdata[DW-1:0];
                got_ang = m_tdata[2*DW-1:DW];
                if (polar_expected.size() == 0) begin
                    report_mismatch($sformatf("result mag=%0d ang=%0d with no point waiting",
                                              got_mag, got_ang));
                end else begin
                    want = polar_expected.pop_front();
                    if (got_mag !== want.mag) begin
                        report_mismatch($sformatf("(%0d,%0d) magnitude %0d, expected %0d",
                                                  want.x, want.y, got_mag, want.mag));
                    end
                    if (got_ang !== want.ang) begin
                        report_mismatch($sformatf("(%0d,%0d) angle %0d, expected %0d",
                                                  want.x, want.y, got_ang, want.ang));
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= polar_expected.size();
    end

endmodule

### verif/tb_top.sv
// Top of the rectangular-to-polar converter testbench: clock, reset and stimulus.
// Depends on rtp_pkg, rect_to_polar_converter and the rtp_checker scoreboard.
module tb_top
    import rtp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW           = DEF_DATA_WIDTH;
    localparam int ITERATIONS   = DEF_ITERATIONS;
    localparam int BUS_W        = ((2*DW+7)/8)*8;
    // Pipeline depth as given for the block: folding, one stage per rotation,
    // gain product and rounding.
    localparam int LATENCY      = ITERATIONS + 3;
    localparam int RANDOM_BEATS = 550;
    // The limit lies well above the slowest legal run, in which every beat sees a
    // full gap on the sender plus a full stall on the receiver.
    localparam int CYCLE_LIMIT  = 200000;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [BUS_W-1:0] s_tdata;    // x_coord, y_coord
    logic             m_tvalid;
    logic             m_tready;
    logic [BUS_W-1:0] m_tdata;    // magnitude, phase_angle

    int fail_count;
    int pending;
    int cycle_count = 0;
    // Largest idle gap either side may draw in the current stretch of the run.
    // Zero gives stretches in which both channels run at full rate.
    int idle_max    = 12;

    rect_to_polar_converter #(
        .DATA_WIDTH (DW),
        .ITERATIONS (ITERATIONS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rtp_checker #(
        .DATA_WIDTH (DW),
        .ITERATIONS (ITERATIONS),
        .BUS_W      (BUS_W)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sends one point as a beat. The sender first idles for a random number of
    // cycles, then holds tvalid and the data until the beat is taken. With no
    // gap, tvalid simply stays high into the next beat.
    task automatic send_point(input logic signed [DW-1:0] px, input logic signed [DW-1:0] py);
        int gap;
        gap = $urandom_range(0, idle_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tdata  <= BUS_W'({py, px});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Receiver: before each result beat it holds tready low for a random
    // number of cycles, then keeps it high until a beat has been taken.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, idle_max);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed points. The origin must give zero on both fields. The axes
        // and corners cover the field extremes, and points just left of the
        // origin exercise the half-turn fold. Points hugging the negative x
        // axis from above round to +pi, which must wrap to the most negative
        // angle.
        send_point(16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
        send_point(16'sd0, 16'sd32767);
        send_point(16'sd0, -16'sd32768);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd1, 16'sd0);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sd1, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(16'sd1, -16'sd1);
        send_point(-16'sd32768, 16'sd1);
        send_point(-16'sd32768, -16'sd1);
        send_point(16'sd100, -16'sd100);
        send_point(-16'sd100, 16'sd100);
        send_point(16'sd32767, 16'sd1);
        send_point(16'sd1, 16'sd32767);

        // Random points. Half are uniform over the whole plane, which toggles
        // every input bit; the rest crowd the origin, the axes, the range ends
        // and the wrap of the angle near the negative x axis.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 60 == 0) begin
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    px = DW'($urandom);
                    py = DW'($urandom);
                end
                5, 6: begin
                    px = DW'($urandom_range(0, 8) - 4);
                    py = DW'($urandom_range(0, 8) - 4);
                end
                7: begin
                    px = DW'($urandom);
                    py = DW'($urandom);
                    if ($urandom_range(0, 1)) px = '0;
                    else py = '0;
                end
                8: begin
                    px = $urandom_range(0, 1) ? DW'(16'sh7FFF - $urandom_range(0, 2))
                                              : DW'(-16'sd32768 + $urandom_range(0, 2));
                    py = $urandom_range(0, 1) ? DW'(16'sh7FFF - $urandom_range(0, 2))
                                              : DW'(-16'sd32768 + $urandom_range(0, 2));
                end
                default: begin
                    px = DW'(-16'sd32768 + $urandom_range(0, 200));
                    py = DW'($urandom_range(0, 6) - 3);
                end
            endcase
            send_point(px, py);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain: wait for every expected result, then give the pipeline time
        // to show any stray beat.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
